/* hdl/gbl_pkg.sv */
package gbl_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 14;

   localparam int AREA_W  = 2 * COORD_BITS + 2;   // signed box area
   localparam int PROD_W  = 2 * COORD_BITS;       // clipped products
   localparam int UNI_W   = 2 * COORD_BITS + 3;   // signed union
   localparam int NUM_W   = 2 * COORD_BITS + 1;   // divider operands
   localparam int QUOT_W  = FRAC_BITS + 2;        // quotient below 4.0
   localparam int PEN_W   = FRAC_BITS + 3;        // penalty up to 4.0
   localparam int LOSS_W  = FRAC_BITS + 2;
   localparam int IOU_W   = FRAC_BITS + 1;
   localparam int SUM_W   = FRAC_BITS + 5;        // signed loss before clipping
   localparam int DIV_LAT = QUOT_W + 1;

   localparam logic [QUOT_W-1:0] ONE_Q = QUOT_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] a_left;
      logic [COORD_BITS-1:0] a_top;
      logic [COORD_BITS-1:0] a_right;
      logic [COORD_BITS-1:0] a_bottom;
      logic [COORD_BITS-1:0] b_left;
      logic [COORD_BITS-1:0] b_top;
      logic [COORD_BITS-1:0] b_right;
      logic [COORD_BITS-1:0] b_bottom;
   } req_type;

   typedef struct packed {
      logic [LOSS_W-1:0] loss_value;
      logic [IOU_W-1:0]  iou_value;
      logic              degenerate;
   } rsp_type;

endpackage

/* hdl/gbl_div.sv */
module gbl_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [gbl_pkg::NUM_W-1:0]        num,
   input  logic [gbl_pkg::NUM_W-1:0]        den,
   output logic [gbl_pkg::QUOT_W-1:0]       quot,
   output logic                             sat
);

   localparam int QW = gbl_pkg::QUOT_W;
   localparam int NW = gbl_pkg::NUM_W;
   localparam int RW = NW + gbl_pkg::FRAC_BITS + 2;

   logic [RW-1:0] rem_ff [QW+1];
   logic [NW-1:0] den_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          sat_ff [QW+1];

   // entry stage: integer part of 4 or more saturates
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num) << gbl_pkg::FRAC_BITS;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= ({2'b00, num} >= {den, 2'b00});
      end
   end

   // one quotient bit per stage, msb first
   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int P = QW - 1 - j;
      logic [RW-1:0] trial;
      logic          take;
      always_comb begin
         trial = RW'(den_ff[j]) << P;
         take  = (rem_ff[j] >= trial);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= take ? (rem_ff[j] - trial) : rem_ff[j];
            den_ff[j+1] <= den_ff[j];
            q_ff[j+1]   <= q_ff[j] | (take ? (QW'(1) << P) : '0);
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   assign quot = q_ff[QW];
   assign sat  = sat_ff[QW];

endmodule

/* hdl/giou_box_loss_unit.sv */
// generalized iou loss of one box pair per cycle unless a stalled result holds the pipeline
// pipeline: 4 front stages, a 17-stage divider pair (an entry stage, then one quotient bit
//   per stage) and an output register
// throughput: one item per cycle; a stalled result holds the whole pipeline
// reset: synchronous, clears the stage valid bits only
module giou_box_loss_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gbl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gbl_pkg::rsp_type  rsp_data
);

   localparam int CB  = gbl_pkg::COORD_BITS;
   localparam int DL  = gbl_pkg::DIV_LAT;
   localparam int NST = 5 + DL;

   logic en;
   logic [NST-1:0] vld_ff;

   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 1: edge differences and clipped spans
   logic signed [CB:0] wa_in, ha_in, wb_in, hb_in;
   logic signed [CB:0] wa_ff, ha_ff, wb_ff, hb_ff;
   logic [CB-1:0] iw_in, ih_in, ow_in, oh_in;
   logic [CB-1:0] iw_ff, ih_ff, ow_ff, oh_ff;
   logic [CB-1:0] minr, maxl, minb, maxt, maxr, minl, maxb, mint;

   always_comb begin
      wa_in = $signed({1'b0, req_data.a_right})  - $signed({1'b0, req_data.a_left});
      ha_in = $signed({1'b0, req_data.a_bottom}) - $signed({1'b0, req_data.a_top});
      wb_in = $signed({1'b0, req_data.b_right})  - $signed({1'b0, req_data.b_left});
      hb_in = $signed({1'b0, req_data.b_bottom}) - $signed({1'b0, req_data.b_top});
      minr = (req_data.a_right < req_data.b_right) ? req_data.a_right : req_data.b_right;
      maxr = (req_data.a_right < req_data.b_right) ? req_data.b_right : req_data.a_right;
      maxl = (req_data.a_left > req_data.b_left) ? req_data.a_left : req_data.b_left;
      minl = (req_data.a_left > req_data.b_left) ? req_data.b_left : req_data.a_left;
      minb = (req_data.a_bottom < req_data.b_bottom) ? req_data.a_bottom : req_data.b_bottom;
      maxb = (req_data.a_bottom < req_data.b_bottom) ? req_data.b_bottom : req_data.a_bottom;
      maxt = (req_data.a_top > req_data.b_top) ? req_data.a_top : req_data.b_top;
      mint = (req_data.a_top > req_data.b_top) ? req_data.b_top : req_data.a_top;
      iw_in = (minr > maxl) ? (minr - maxl) : '0;
      ih_in = (minb > maxt) ? (minb - maxt) : '0;
      ow_in = (maxr > minl) ? (maxr - minl) : '0;
      oh_in = (maxb > mint) ? (maxb - mint) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wa_ff <= wa_in;
         ha_ff <= ha_in;
         wb_ff <= wb_in;
         hb_ff <= hb_in;
         iw_ff <= iw_in;
         ih_ff <= ih_in;
         ow_ff <= ow_in;
         oh_ff <= oh_in;
      end
   end

   // stage 2: areas
   logic signed [gbl_pkg::AREA_W-1:0] area_a_ff, area_b_ff;
   logic [gbl_pkg::PROD_W-1:0] inter_ff, encl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         area_a_ff <= gbl_pkg::AREA_W'(wa_ff * ha_ff);
         area_b_ff <= gbl_pkg::AREA_W'(wb_ff * hb_ff);
         inter_ff  <= gbl_pkg::PROD_W'(iw_ff * ih_ff);
         encl_ff   <= gbl_pkg::PROD_W'(ow_ff * oh_ff);
      end
   end

   // stage 3: union and degenerate check
   logic signed [gbl_pkg::UNI_W-1:0] uni_in, uni_ff;
   logic [gbl_pkg::PROD_W-1:0] inter3_ff, encl3_ff;
   logic deg3_ff;

   assign uni_in = gbl_pkg::UNI_W'(area_a_ff) + gbl_pkg::UNI_W'(area_b_ff)
                 - $signed({3'b000, inter_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         uni_ff    <= uni_in;
         inter3_ff <= inter_ff;
         encl3_ff  <= encl_ff;
         deg3_ff   <= (uni_in <= 0) || (encl_ff == '0);
      end
   end

   // stage 4: divider operands
   logic signed [gbl_pkg::UNI_W-1:0] encl_s;
   logic pen_ge;
   logic [gbl_pkg::NUM_W-1:0] n_iou_ff, d_iou_ff, n_pen_ff, d_pen_ff;
   logic signed [gbl_pkg::UNI_W-1:0] pen_diff;
   logic neg4_ff, deg4_ff;

   always_comb begin
      encl_s   = $signed({3'b000, encl3_ff});
      pen_ge   = (encl_s >= uni_ff);
      pen_diff = pen_ge ? (encl_s - uni_ff) : (uni_ff - encl_s);
   end

   // degenerate items get a harmless divisor of one
   always_ff @(posedge clock) begin
      if (en) begin
         n_iou_ff <= gbl_pkg::NUM_W'(inter3_ff);
         d_iou_ff <= deg3_ff ? gbl_pkg::NUM_W'(1) : uni_ff[gbl_pkg::NUM_W-1:0];
         n_pen_ff <= pen_diff[gbl_pkg::NUM_W-1:0];
         d_pen_ff <= deg3_ff ? gbl_pkg::NUM_W'(1) : gbl_pkg::NUM_W'(encl3_ff);
         neg4_ff  <= !pen_ge;
         deg4_ff  <= deg3_ff;
      end
   end

   // divider pair
   logic [gbl_pkg::QUOT_W-1:0] q_iou, q_pen;
   logic sat_iou, sat_pen;

   gbl_div u_div_iou (
      .clock (clock),
      .en    (en),
      .num   (n_iou_ff),
      .den   (d_iou_ff),
      .quot  (q_iou),
      .sat   (sat_iou)
   );

   gbl_div u_div_pen (
      .clock (clock),
      .en    (en),
      .num   (n_pen_ff),
      .den   (d_pen_ff),
      .quot  (q_pen),
      .sat   (sat_pen)
   );

   logic neg_ff [DL];
   logic deg_ff [DL];

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= neg4_ff;
         deg_ff[0] <= deg4_ff;
         for (int i = 1; i < DL; i++) begin
            neg_ff[i] <= neg_ff[i-1];
            deg_ff[i] <= deg_ff[i-1];
         end
      end
   end

   // output stage: combine, clip, register
   logic [gbl_pkg::QUOT_W-1:0] iou_q;
   logic [gbl_pkg::PEN_W-1:0] pen_q;
   logic signed [gbl_pkg::SUM_W-1:0] loss_s;
   logic [gbl_pkg::LOSS_W-1:0] loss_c;
   gbl_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      if (sat_iou || (q_iou > gbl_pkg::ONE_Q)) begin
         iou_q = gbl_pkg::ONE_Q;
      end else begin
         iou_q = q_iou;
      end
      pen_q = sat_pen ? (gbl_pkg::PEN_W'(gbl_pkg::ONE_Q) << 2) : gbl_pkg::PEN_W'(q_pen);
      loss_s = $signed(gbl_pkg::SUM_W'(gbl_pkg::ONE_Q)) - $signed(gbl_pkg::SUM_W'(iou_q));
      if (neg_ff[DL-1]) begin
         loss_s = loss_s - $signed(gbl_pkg::SUM_W'(pen_q));
      end else begin
         loss_s = loss_s + $signed(gbl_pkg::SUM_W'(pen_q));
      end
      if (loss_s < 0) begin
         loss_c = '0;
      end else if (loss_s > $signed(gbl_pkg::SUM_W'(gbl_pkg::ONE_Q) << 1)) begin
         loss_c = gbl_pkg::LOSS_W'(gbl_pkg::ONE_Q) << 1;
      end else begin
         loss_c = loss_s[gbl_pkg::LOSS_W-1:0];
      end
      if (deg_ff[DL-1]) begin
         rsp_in.loss_value = gbl_pkg::LOSS_W'(gbl_pkg::ONE_Q) << 1;
         rsp_in.iou_value  = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.loss_value = loss_c;
         rsp_in.iou_value  = iou_q[gbl_pkg::IOU_W-1:0];
         rsp_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = rsp_ff;

   a_deg_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.iou_value == '0 &&
         rsp_data.loss_value == (gbl_pkg::LOSS_W'(gbl_pkg::ONE_Q) << 1))
      else $error("degenerate item with wrong values");

   a_iou_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.iou_value <= gbl_pkg::IOU_W'(gbl_pkg::ONE_Q))
      else $error("iou above one");

   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.loss_value <= (gbl_pkg::LOSS_W'(gbl_pkg::ONE_Q) << 1))
      else $error("loss above two");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule
